/* hw/rtl/signed_binary_to_decimal_ascii_macros.svh */
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_MACROS_SVH

// Clocked check, off while reset is asserted.
`define SBDA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define SBDA_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/sbda_pkg.sv */
package sbda_pkg;

	localparam int FIELD_BITS = 32;
	localparam int STEP_BITS  = 4;   // magnitude bits folded into BCD per convert step
	localparam int CHAR_W     = 7;
	localparam int PC_W       = 3;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
	localparam logic [CHAR_W-1:0] CHAR_POINT = 7'h2e;

	localparam logic [PC_W-1:0] STEP_IDLE      = 3'd0;
	localparam logic [PC_W-1:0] STEP_LOAD_INT  = 3'd1;
	localparam logic [PC_W-1:0] STEP_CONV      = 3'd2;
	localparam logic [PC_W-1:0] STEP_EMIT      = 3'd3;
	localparam logic [PC_W-1:0] STEP_TEST      = 3'd4;
	localparam logic [PC_W-1:0] STEP_POINT     = 3'd5;
	localparam logic [PC_W-1:0] STEP_LOAD_FRAC = 3'd6;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_IDLE,
		OP_LOAD,
		OP_CONV,
		OP_EMIT,
		OP_POINT
	} op_t;

	// branch is taken to target when the condition holds, else pc + 1
	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_START,
		COND_CNT_MORE,
		COND_DIG_MORE,
		COND_NO_FRAC
	} cond_t;

	typedef struct packed {
		op_t             op;
		logic            src_frac;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic signed [FIELD_BITS-1:0] integer_part;
		logic signed [FIELD_BITS-1:0] fraction_part;
		logic                         with_fraction;
	} item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              last;
	} char_t;

	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t w;
		case (pc)
			STEP_IDLE:      w = '{OP_IDLE,  1'b0, COND_NO_START, STEP_IDLE};
			STEP_LOAD_INT:  w = '{OP_LOAD,  1'b0, COND_NEVER,    STEP_IDLE};
			STEP_CONV:      w = '{OP_CONV,  1'b0, COND_CNT_MORE, STEP_CONV};
			STEP_EMIT:      w = '{OP_EMIT,  1'b0, COND_DIG_MORE, STEP_EMIT};
			STEP_TEST:      w = '{OP_NOP,   1'b0, COND_NO_FRAC,  STEP_IDLE};
			STEP_POINT:     w = '{OP_POINT, 1'b0, COND_NEVER,    STEP_IDLE};
			STEP_LOAD_FRAC: w = '{OP_LOAD,  1'b1, COND_ALWAYS,   STEP_CONV};
			default:        w = '{OP_NOP,   1'b0, COND_ALWAYS,   STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

/* hw/rtl/signed_binary_to_decimal_ascii.sv */
// Signed binary to decimal ASCII. Pulse start while busy is low to transfer one item; the
// characters follow on text, one per strobe cycle, most significant digit first, and the
// final one has text.last set. The receiver cannot stall: every strobe is a transfer. The
// block works on one item at a time under a small microprogram. Each number passes a load
// step (which also sends '-' when negative), double-dabble convert steps of STEP_BITS bits
// each and an emit step for each BCD digit slot (10 at 32 bits), leading zeros being
// skipped in silence; an item also passes an accept step and a fraction test, and in
// fraction mode a step that sends '.' before the fraction is converted in the same way.
module signed_binary_to_decimal_ascii
	import sbda_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  item_t value,
	output logic  busy,
	output logic  strobe,
	output char_t text
);

	`include "signed_binary_to_decimal_ascii_macros.svh"

	localparam int EXT_W      = (VALUE_BITS > FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
	localparam int MAG_P      = ((VALUE_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
	localparam int CONV_STEPS = MAG_P / STEP_BITS;
	localparam int CONV_W     = $clog2(CONV_STEPS + 1);
	localparam int NDIG       = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int DIG_W      = $clog2(NDIG + 1);
	localparam int BCD_W      = 4 * NDIG;

	logic [PC_W-1:0]   pc_q;
	item_t             item_q;
	logic              frac_q;
	logic              started_q;
	logic [CONV_W-1:0] conv_cnt_q;
	logic [DIG_W-1:0]  dig_cnt_q;
	logic [MAG_P-1:0]  mag_q;
	logic [BCD_W-1:0]  bcd_q;
	logic              strobe_q;
	char_t             text_q;

	ctrl_t                  ctrl;
	logic signed [FIELD_BITS-1:0] src;
	logic [EXT_W-1:0]       ext;
	logic [VALUE_BITS-1:0]  v;
	logic                   neg;
	logic [VALUE_BITS-1:0]  mag;
	logic [BCD_W+MAG_P-1:0] dd;
	logic [3:0]             top_dig;
	logic                   dig_last;
	logic                   emit_now;
	logic                   frac_done;
	logic                   taken;

	always_comb begin
		ctrl = ucode(pc_q);
		src  = ctrl.src_frac ? item_q.fraction_part : item_q.integer_part;
		ext  = EXT_W'($unsigned(src));
		v    = ext[VALUE_BITS-1:0];
		neg  = v[VALUE_BITS-1];
		mag  = neg ? (~v + VALUE_BITS'(1)) : v;
	end

	// shift-add-3, STEP_BITS bits per cycle
	always_comb begin
		dd = {bcd_q, mag_q};
		for (int j = 0; j < STEP_BITS; j++) begin
			for (int d = 0; d < NDIG; d++) begin
				if (dd[MAG_P + 4*d +: 4] >= 4'd5) begin
					dd[MAG_P + 4*d +: 4] = dd[MAG_P + 4*d +: 4] + 4'd3;
				end
			end
			dd = dd << 1;
		end
	end

	always_comb begin
		top_dig   = bcd_q[BCD_W-1 -: 4];
		dig_last  = (dig_cnt_q == DIG_W'(1));
		emit_now  = started_q || (top_dig != 4'd0) || dig_last;
		frac_done = !item_q.with_fraction || frac_q;
		case (ctrl.cond)
			COND_NEVER:    taken = 1'b0;
			COND_ALWAYS:   taken = 1'b1;
			COND_NO_START: taken = !start;
			COND_CNT_MORE: taken = (conv_cnt_q != CONV_W'(1));
			COND_DIG_MORE: taken = !dig_last;
			COND_NO_FRAC:  taken = frac_done;
			default:       taken = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= STEP_IDLE;
			strobe_q  <= 1'b0;
			frac_q    <= 1'b0;
			started_q <= 1'b0;
		end else begin
			pc_q     <= taken ? ctrl.target : pc_q + PC_W'(1);
			strobe_q <= 1'b0;
			case (ctrl.op)
				OP_IDLE: begin
					frac_q <= 1'b0;
				end
				OP_LOAD: begin
					strobe_q  <= neg;
					started_q <= 1'b0;
					if (ctrl.src_frac) begin
						frac_q <= 1'b1;
					end
				end
				OP_EMIT: begin
					strobe_q <= emit_now;
					if (emit_now) begin
						started_q <= 1'b1;
					end
				end
				OP_POINT: begin
					strobe_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_IDLE: begin
				if (start) begin
					item_q <= value;
				end
			end
			OP_LOAD: begin
				mag_q          <= MAG_P'(mag);
				bcd_q          <= '0;
				conv_cnt_q     <= CONV_W'(CONV_STEPS);
				dig_cnt_q      <= DIG_W'(NDIG);
				text_q         <= '{CHAR_MINUS, 1'b0};
			end
			OP_CONV: begin
				{bcd_q, mag_q} <= dd;
				conv_cnt_q     <= conv_cnt_q - CONV_W'(1);
			end
			OP_EMIT: begin
				bcd_q     <= bcd_q << 4;
				dig_cnt_q <= dig_cnt_q - DIG_W'(1);
				text_q    <= '{CHAR_ZERO + {3'b000, top_dig}, dig_last && frac_done};
			end
			OP_POINT: begin
				text_q <= '{CHAR_POINT, 1'b0};
			end
			default: begin
			end
		endcase
	end

	assign busy   = (pc_q != STEP_IDLE);
	assign strobe = strobe_q;
	assign text   = text_q;

	`SBDA_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted item did not raise busy")
	`SBDA_ASSERT(a_more_busy, strobe && !text.last |-> busy, "item ended without a last char")
	`SBDA_ASSERT(a_last_gap, strobe && text.last |=> !strobe, "char transfer right after last")
	`SBDA_ASSERT_ALWAYS(a_conv_cnt, pc_q == STEP_CONV |-> conv_cnt_q != '0,
		"convert step with empty counter")

endmodule

/* tb/sv/signed_binary_to_decimal_ascii_tb.sv */
`timescale 1ns / 100ps

module signed_binary_to_decimal_ascii_tb;
	import sbda_pkg::*;

	localparam int RANDOM_ITEMS = 330;
	localparam int QUIET_ITEMS  = 50;
	localparam int DRAIN_CYCLES = 60;
	localparam int N_DIRECTED   = 22;

	typedef char_t char_q_t[$];

	typedef struct {
		logic [FIELD_BITS-1:0] int_val;
		logic [FIELD_BITS-1:0] frac_val;
		logic                  frac_on;
		string                 text;     // empty: expectation comes from the predictor
	} directed_row_t;

	logic  clk;
	logic  arst_n;
	logic  start;
	item_t value;
	logic  busy;
	logic  strobe;
	char_t text;

	char_t         pending_chars[$];
	int            mismatch_count;
	directed_row_t directed_rows[N_DIRECTED];

	signed_binary_to_decimal_ascii dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.value  (value),
		.busy   (busy),
		.strobe (strobe),
		.text   (text)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("tb: failure");
		$finish;
	end

	// Decimal text of one two's complement value; the most negative one keeps its
	// magnitude since the unsigned negate of 0x80000000 is itself.
	function automatic char_q_t decimal_chars(input logic [FIELD_BITS-1:0] raw);
		char_q_t               chars;
		logic [FIELD_BITS-1:0] mag;
		logic [CHAR_W-1:0]     digits[$];
		mag = raw[FIELD_BITS-1] ? (~raw + 1'b1) : raw;
		do begin
			digits.push_front(CHAR_ZERO + CHAR_W'(mag % 10));
			mag = mag / 10;
		end while (mag != 0);
		if (raw[FIELD_BITS-1])
			chars.push_back('{CHAR_MINUS, 1'b0});
		foreach (digits[i])
			chars.push_back('{digits[i], 1'b0});
		return chars;
	endfunction

	function automatic char_q_t predict_item(input item_t it);
		char_q_t chars;
		chars = decimal_chars(it.integer_part);
		if (it.with_fraction) begin
			chars.push_back('{CHAR_POINT, 1'b0});
			chars = {chars, decimal_chars(it.fraction_part)};
		end
		chars[chars.size()-1].last = 1'b1;
		return chars;
	endfunction

	function automatic char_q_t text_chars(input string s);
		char_q_t chars;
		byte     c;
		for (int i = 0; i < s.len(); i++) begin
			c = s[i];
			chars.push_back('{c[CHAR_W-1:0], i == s.len() - 1});
		end
		return chars;
	endfunction

	function automatic int idle_gap(input bit allowed);
		if (allowed && $urandom_range(0, 2) == 0)
			return $urandom_range(1, 4);
		return 0;
	endfunction

	function automatic logic [FIELD_BITS-1:0] random_number();
		logic [FIELD_BITS-1:0] v;
		longint unsigned       bound;
		case ($urandom_range(0, 5))
			0: v = $urandom;
			1: v = $urandom_range(0, 9);
			2: begin
				case ($urandom_range(0, 4))
					0: v = 32'h8000_0000;
					1: v = 32'h7fff_ffff;
					2: v = 32'h0000_0000;
					3: v = 32'hffff_ffff;
					default: v = 32'h8000_0001;
				endcase
			end
			default: begin
				// spread over decimal lengths rather than bit lengths
				bound = 1;
				repeat ($urandom_range(1, 10)) bound = bound * 10;
				v = FIELD_BITS'(longint'($urandom) % bound);
			end
		endcase
		if ($urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	// Drives one item and waits for its transfer; expectations are queued on acceptance.
	task automatic send_item(input item_t it, input char_q_t chars, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		value <= it;
		do @(posedge clk); while (busy);
		foreach (chars[i])
			pending_chars.push_back(chars[i]);
	endtask

	always @(posedge clk) begin
		char_t want;
		if (arst_n && strobe) begin
			if (pending_chars.size() == 0) begin
				$error("char_code unexpected: actual %h", text.char_code);
				mismatch_count++;
			end else begin
				want = pending_chars.pop_front();
				if (text.char_code !== want.char_code) begin
					$error("char_code expected %h actual %h", want.char_code, text.char_code);
					mismatch_count++;
				end
				if (text.last !== want.last) begin
					$error("last expected %b actual %b", want.last, text.last);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		item_t   it;
		char_q_t chars;
		bit      bursts_on;

		mismatch_count = 0;
		arst_n <= 1'b0;
		start  <= 1'b0;
		value  <= '0;

		directed_rows = '{
			'{32'd0,          32'd0,          1'b0, "0"},
			'{32'd1,          32'd0,          1'b0, "1"},
			'{32'hffff_ffff,  32'd0,          1'b0, "-1"},
			'{32'h7fff_ffff,  32'd0,          1'b0, "2147483647"},
			'{32'h8000_0000,  32'd0,          1'b0, "-2147483648"},
			'{32'd9,          32'd0,          1'b0, "9"},
			'{32'd10,         32'd0,          1'b0, "10"},
			'{32'd1000000000, 32'd0,          1'b0, "1000000000"},
			'{32'd999999999,  32'd0,          1'b0, "999999999"},
			'{32'd0,          32'd0,          1'b1, "0.0"},
			'{32'd12,         32'd0,          1'b1, "12.0"},
			'{32'd3,          32'd5,          1'b1, "3.5"},
			'{32'd5,          32'hffff_fff9,  1'b1, "5.-7"},
			'{32'hffff_ffff,  32'd1,          1'b1, "-1.1"},
			'{32'd1,          32'd5,          1'b0, "1"},
			'{32'd7,          32'h8000_0000,  1'b0, "7"},
			'{32'h8000_0000,  32'h8000_0000,  1'b1, "-2147483648.-2147483648"},
			'{32'h7fff_ffff,  32'h7fff_ffff,  1'b1, "2147483647.2147483647"},
			'{32'h5555_5555,  32'haaaa_aaaa,  1'b1, ""},
			'{32'haaaa_aaaa,  32'h5555_5555,  1'b1, ""},
			'{32'h8000_0001,  32'h0000_0064,  1'b1, ""},
			'{32'h0001_e240,  32'hfffe_1dc0,  1'b0, ""}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			it.integer_part  = directed_rows[i].int_val;
			it.fraction_part = directed_rows[i].frac_val;
			it.with_fraction = directed_rows[i].frac_on;
			chars = (directed_rows[i].text != "") ? text_chars(directed_rows[i].text)
			                                      : predict_item(it);
			send_item(it, chars, idle_gap(1'b1));
		end

		bursts_on = 1'b1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// alternate stretches with and without start gaps; none near the end
			if ($urandom_range(0, 24) == 0)
				bursts_on = !bursts_on;
			it.integer_part  = random_number();
			it.fraction_part = random_number();
			it.with_fraction = 1'($urandom_range(0, 1));
			send_item(it, predict_item(it),
			          idle_gap(bursts_on && n < RANDOM_ITEMS - QUIET_ITEMS));
		end
		start <= 1'b0;

		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* signed_binary_to_decimal_ascii.f */
+incdir+hw/rtl
hw/rtl/sbda_pkg.sv
hw/rtl/signed_binary_to_decimal_ascii.sv
tb/sv/signed_binary_to_decimal_ascii_tb.sv
